>>> design/tcp_segment_receive_checker_unit_assert.svh
// Assertion macros used by the back end of the TCP segment checker.
`ifndef TCP_SEGMENT_RECEIVE_CHECKER_UNIT_ASSERT_SVH
`define TCP_SEGMENT_RECEIVE_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a condition on every clock edge outside reset.
`define TCSRC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define TCSRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TCSRC_ASSERT_ALWAYS(label, cond)
`define TCSRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/tcsrc_pkg.sv
// Types and constants of the TCP segment receive checker.
package tcsrc_pkg;

	localparam int SUM_W            = 32;
	localparam int CNT_W            = 17;
	localparam int MIN_HEADER_BYTES = 20;
	localparam int MIN_DATA_OFFSET  = 5;
	localparam logic [7:0]  TCP_PROTOCOL = 8'h06;
	localparam logic [15:0] WORD_MASK    = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_OFFSET   = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [7:0]  offset_byte;
		logic [7:0]  flag_bits;
		logic [15:0] window;
		logic [15:0] checksum_word;
		logic [15:0] urgent_pointer;
	} tcp_hdr_t;

	// Summary of one finished segment, handed from front to back.
	typedef struct packed {
		tcp_hdr_t         hdr;
		logic [SUM_W-1:0] sum;
		logic [7:0]       pend;
		logic [CNT_W-1:0] cnt;
	} seg_rec_t;

endpackage

>>> design/tcsrc_queue.sv
// Small register FIFO between the front and back of the checker.
module tcsrc_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	logic [W-1:0]      mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] fill_q;
	logic              push, pop;

	assign push_ready = (fill_q != CNT_QW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> design/tcsrc_front.sv
// Byte-level front end: header capture, raw checksum accumulation, byte count.
module tcsrc_front
	import tcsrc_pkg::*;
#(
	parameter int MAX_SEGMENT_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic        last,
	output logic        rec_valid,
	input  logic        rec_ready,
	output seg_rec_t    rec
);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [SUM_W-1:0] acc_q, acc_n, pseudo;
	logic [7:0]       pend_q, pend_n;
	tcp_hdr_t         hdr_q, hdr_n;
	logic             first, take, accept;

	assign in_ready  = rec_ready;
	assign accept    = in_valid && in_ready;
	assign rec_valid = in_valid && last;

	always_comb begin
		first  = (cnt_q == '0);
		take   = (cnt_q < CNT_W'(MAX_SEGMENT_BYTES));
		pseudo = SUM_W'(src_addr[31:16]) + SUM_W'(src_addr[15:0])
		       + SUM_W'(dst_addr[31:16]) + SUM_W'(dst_addr[15:0])
		       + SUM_W'(TCP_PROTOCOL);
		cnt_n  = cnt_q;
		pend_n = pend_q;
		hdr_n  = hdr_q;
		// The first byte is at an even position and adds no word itself.
		acc_n  = first ? pseudo : acc_q;
		if (take) begin
			cnt_n = cnt_q + 1'b1;
			if (cnt_q[0]) begin
				acc_n = acc_q + SUM_W'({pend_q, data_byte});
			end else begin
				pend_n = data_byte;
			end
			case (cnt_q) inside
				[0:1]:   hdr_n.source_port    = {hdr_q.source_port[7:0], data_byte};
				[2:3]:   hdr_n.dest_port      = {hdr_q.dest_port[7:0], data_byte};
				[4:7]:   hdr_n.seq_number     = {hdr_q.seq_number[23:0], data_byte};
				[8:11]:  hdr_n.ack_number     = {hdr_q.ack_number[23:0], data_byte};
				12:      hdr_n.offset_byte    = data_byte;
				13:      hdr_n.flag_bits      = data_byte;
				[14:15]: hdr_n.window         = {hdr_q.window[7:0], data_byte};
				[16:17]: hdr_n.checksum_word  = {hdr_q.checksum_word[7:0], data_byte};
				[18:19]: hdr_n.urgent_pointer = {hdr_q.urgent_pointer[7:0], data_byte};
				default: ;
			endcase
		end
		rec.hdr  = hdr_n;
		rec.sum  = acc_n;
		rec.pend = pend_n;
		rec.cnt  = cnt_n;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			acc_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			// Restart the segment after the last byte.
			if (last) begin
				cnt_q  <= '0;
				acc_q  <= '0;
				pend_q <= '0;
			end else begin
				cnt_q  <= cnt_n;
				acc_q  <= acc_n;
				pend_q <= pend_n;
			end
		end
	end

endmodule

>>> design/tcsrc_back.sv
// Segment back end: final sum, checksum fold, status decision, output register.
module tcsrc_back
	import tcsrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rec_valid,
	output logic     rec_ready,
	input  seg_rec_t rec,
	output logic     out_valid,
	input  logic     out_ready,
	output status_t  status,
	output tcp_hdr_t hdr
);

	`include "tcp_segment_receive_checker_unit_assert.svh"

	logic             v_s1, v_s2;
	logic [SUM_W-1:0] sum_s1;
	status_t          pre_s1;
	tcp_hdr_t         hdr_s1;
	status_t          status_s2;
	tcp_hdr_t         hdr_s2;
	logic             adv_s1, adv_s0;
	logic [SUM_W-1:0] pad, total;
	logic [3:0]       offs;
	status_t          pre;
	logic [16:0]      fold1;
	logic [15:0]      fold2;
	status_t          fin;

	assign adv_s1    = v_s1 && (!v_s2 || out_ready);
	assign adv_s0    = rec_valid && (!v_s1 || adv_s1);
	assign rec_ready = !v_s1 || adv_s1;
	assign out_valid = v_s2;
	assign status    = status_s2;
	assign hdr       = hdr_s2;

	always_comb begin
		pad   = rec.cnt[0] ? SUM_W'({rec.pend, 8'h00}) : '0;
		total = rec.sum + pad + SUM_W'(rec.cnt[15:0]);
		offs  = rec.hdr.offset_byte[7:4];
		if (rec.cnt < CNT_W'(MIN_HEADER_BYTES)) begin
			pre = ST_SHORT;
		end else if (offs < 4'(MIN_DATA_OFFSET)) begin
			pre = ST_OFFSET;
		end else if (rec.cnt < CNT_W'({offs, 2'b00})) begin
			pre = ST_TRUNC;
		end else begin
			pre = ST_OK;
		end
	end

	// Fold the plain sum with end-around carry; a good segment folds to all ones.
	always_comb begin
		fold1 = 17'(sum_s1[31:16]) + 17'(sum_s1[15:0]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		if (pre_s1 != ST_OK) begin
			fin = pre_s1;
		end else if (fold2 != WORD_MASK) begin
			fin = ST_CHECKSUM;
		end else begin
			fin = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s0) begin
			sum_s1 <= total;
			pre_s1 <= pre;
			hdr_s1 <= rec.hdr;
		end
		if (adv_s1) begin
			status_s2 <= fin;
			hdr_s2    <= (fin == ST_OK) ? hdr_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s0) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	`TCSRC_ASSERT_ALWAYS(a_fail_zero_hdr, !(v_s2 && status_s2 != ST_OK) || hdr_s2 == '0)
	`TCSRC_ASSERT_ALWAYS(a_ok_offset, !(v_s2 && status_s2 == ST_OK) || hdr_s2.offset_byte[7:4] >= 4'(MIN_DATA_OFFSET))
	`TCSRC_ASSERT_NEXT(a_s1_hold, v_s1 && !adv_s1, v_s1 && $stable(sum_s1))

endmodule

>>> design/tcp_segment_receive_checker_unit.sv
// Top level of the TCP segment receive checker.
//
// Takes one TCP segment byte per cycle on the slave stream (s_tlast on the final
// byte) with the IPv4 addresses sampled on the first byte, and returns one result
// per segment on the master stream: status and the captured header fields, all
// header fields zero unless the status is ok. The per-byte work is a single add
// into a plain 32-bit sum. A finished segment's summary enters a two-entry queue,
// and the back end folds the sum and decides the status in two registered stages.
// s_tready drops only while the queue is full.
module tcp_segment_receive_checker_unit
	import tcsrc_pkg::*;
#(
	parameter int MAX_SEGMENT_BYTES = 65535
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], source_port[18:3], dest_port[34:19], seq_number[66:35],
	// ack_number[98:67], offset_byte[106:99], flag_bits[114:107],
	// window[130:115], checksum_word[146:131], urgent_pointer[162:147], zeros above
	output logic [167:0] m_tdata
);

	logic     f_valid, f_ready, q_valid, q_ready;
	seg_rec_t f_rec, q_rec;
	status_t  status;
	tcp_hdr_t hdr;

	tcsrc_front #(
		.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.data_byte (s_tdata[7:0]),
		.src_addr  (s_tdata[39:8]),
		.dst_addr  (s_tdata[71:40]),
		.last      (s_tlast),
		.rec_valid (f_valid),
		.rec_ready (f_ready),
		.rec       (f_rec)
	);

	tcsrc_queue #(
		.W     ($bits(seg_rec_t)),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_rec),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_rec)
	);

	tcsrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.rec       (q_rec),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.hdr       (hdr)
	);

	assign m_tdata = {5'b0, hdr.urgent_pointer, hdr.checksum_word, hdr.window,
		hdr.flag_bits, hdr.offset_byte, hdr.ack_number, hdr.seq_number,
		hdr.dest_port, hdr.source_port, status};

endmodule

>>> verif/tb_tcp_segment_receive_checker_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TCP segment receive checker unit.
module tb_tcp_segment_receive_checker_unit;
	import tcsrc_pkg::*;

	localparam int SEG_LIMIT = 65535;

	typedef logic [7:0] byte_q_t [$];

	typedef struct {
		logic [7:0]  data;
		logic [31:0] src;
		logic [31:0] dst;
		logic        last;
	} wire_beat_t;

	typedef struct {
		status_t  status;
		tcp_hdr_t hdr;
	} segment_verdict_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata  = '0;  // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
	logic         s_tlast  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// status[2:0], source_port[18:3], dest_port[34:19], seq_number[66:35],
	// ack_number[98:67], offset_byte[106:99], flag_bits[114:107],
	// window[130:115], checksum_word[146:131], urgent_pointer[162:147], zeros above
	logic [167:0] m_tdata;

	wire_beat_t       wire_bytes[$];
	segment_verdict_t awaited_verdicts[$];
	int               total_segments = 0;
	int               mismatch_count = 0;
	longint           cycle_count    = 0;
	longint           cycle_limit    = 64'd100_000_000;

	// predictor state for the segment in flight
	logic [16:0] seg_count = '0;
	logic [15:0] seg_sum   = '0;
	logic [7:0]  seg_pend  = '0;
	tcp_hdr_t    seg_hdr   = '0;

	tcp_segment_receive_checker_unit #(
		.MAX_SEGMENT_BYTES(SEG_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Folded sum over pseudo-header and the bytes the block keeps.
	function automatic logic [15:0] segment_sum(byte_q_t seg, logic [31:0] src, logic [31:0] dst);
		logic [15:0] acc;
		int          n;
		acc = ones_add(16'h0000, src[31:16]);
		acc = ones_add(acc, src[15:0]);
		acc = ones_add(acc, dst[31:16]);
		acc = ones_add(acc, dst[15:0]);
		acc = ones_add(acc, {8'h00, TCP_PROTOCOL});
		n = (seg.size() < SEG_LIMIT) ? seg.size() : SEG_LIMIT;
		for (int i = 0; i < n; i += 2)
			acc = ones_add(acc, {seg[i], (i + 1 < n) ? seg[i + 1] : 8'h00});
		return ones_add(acc, n[15:0]);
	endfunction

	// Fill bytes 16-17 so that the segment verifies.
	function automatic byte_q_t sealed(byte_q_t seg, logic [31:0] src, logic [31:0] dst);
		logic [15:0] fix;
		seg[16] = 8'h00;
		seg[17] = 8'h00;
		fix = ~segment_sum(seg, src, dst);
		seg[16] = fix[15:8];
		seg[17] = fix[7:0];
		return seg;
	endfunction

	function automatic byte_q_t header_segment(int len, int doff);
		byte_q_t seg;
		for (int i = 0; i < len; i++)
			seg.push_back(8'($urandom()));
		if (len > 12)
			seg[12] = {4'(doff), seg[12][3:0]};
		return seg;
	endfunction

	task automatic queue_segment(input byte_q_t seg, input logic [31:0] src, input logic [31:0] dst);
		wire_beat_t beat;
		foreach (seg[i]) begin
			beat.data = seg[i];
			// addresses past the first byte are ignored; keep them noisy
			beat.src  = (i == 0) ? src : $urandom();
			beat.dst  = (i == 0) ? dst : $urandom();
			beat.last = (i == seg.size() - 1);
			wire_bytes.push_back(beat);
		end
		total_segments++;
	endtask

	task automatic absorb_segment_byte(input logic [7:0] b, input logic [31:0] src,
		input logic [31:0] dst, input logic last);
		logic [15:0]      total;
		logic [4:0]       doff;
		segment_verdict_t verdict;
		if (seg_count == 0) begin
			seg_sum = ones_add(seg_sum, src[31:16]);
			seg_sum = ones_add(seg_sum, src[15:0]);
			seg_sum = ones_add(seg_sum, dst[31:16]);
			seg_sum = ones_add(seg_sum, dst[15:0]);
			seg_sum = ones_add(seg_sum, {8'h00, TCP_PROTOCOL});
		end
		// drop bytes past the segment limit
		if (seg_count < SEG_LIMIT) begin
			if (seg_count < 2)
				seg_hdr.source_port = {seg_hdr.source_port[7:0], b};
			else if (seg_count < 4)
				seg_hdr.dest_port = {seg_hdr.dest_port[7:0], b};
			else if (seg_count < 8)
				seg_hdr.seq_number = {seg_hdr.seq_number[23:0], b};
			else if (seg_count < 12)
				seg_hdr.ack_number = {seg_hdr.ack_number[23:0], b};
			else if (seg_count == 12)
				seg_hdr.offset_byte = b;
			else if (seg_count == 13)
				seg_hdr.flag_bits = b;
			else if (seg_count < 16)
				seg_hdr.window = {seg_hdr.window[7:0], b};
			else if (seg_count < 18)
				seg_hdr.checksum_word = {seg_hdr.checksum_word[7:0], b};
			else if (seg_count < 20)
				seg_hdr.urgent_pointer = {seg_hdr.urgent_pointer[7:0], b};
			if (!seg_count[0])
				seg_pend = b;
			else
				seg_sum = ones_add(seg_sum, {seg_pend, b});
			seg_count = seg_count + 1'b1;
		end
		if (last) begin
			total = seg_sum;
			if (seg_count[0])
				total = ones_add(total, {seg_pend, 8'h00});
			total = ones_add(total, seg_count[15:0]);
			doff = {1'b0, seg_hdr.offset_byte[7:4]};
			if (seg_count < MIN_HEADER_BYTES)
				verdict.status = ST_SHORT;
			else if (doff < MIN_DATA_OFFSET)
				verdict.status = ST_OFFSET;
			else if (seg_count < 4 * doff)
				verdict.status = ST_TRUNC;
			else if (total != WORD_MASK)
				verdict.status = ST_CHECKSUM;
			else
				verdict.status = ST_OK;
			verdict.hdr = (verdict.status == ST_OK) ? seg_hdr : '0;
			awaited_verdicts.push_back(verdict);
			seg_count = '0;
			seg_sum   = '0;
			seg_pend  = '0;
			seg_hdr   = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Stimulus
	initial begin
		byte_q_t     seg;
		logic [31:0] src;
		logic [31:0] dst;
		int          doff;
		int          pick;
		int          idx;

		// one-byte segment, addresses sampled on its only byte
		seg = {8'hFF};
		queue_segment(seg, '1, '1);
		// short segment with a zero offset nibble: short wins
		seg = header_segment(19, 0);
		queue_segment(seg, 32'h0, 32'hFFFF_FFFF);
		seg = sealed(header_segment(20, 0), 32'h0A00_0001, 32'h0A00_0002);
		queue_segment(seg, 32'h0A00_0001, 32'h0A00_0002);
		seg = sealed(header_segment(20, 4), 32'hC0A8_0101, 32'hC0A8_01FE);
		queue_segment(seg, 32'hC0A8_0101, 32'hC0A8_01FE);
		seg = header_segment(20, 6);
		queue_segment(seg, $urandom(), $urandom());
		src = $urandom();
		dst = $urandom();
		seg = sealed(header_segment(59, 15), src, dst);
		queue_segment(seg, src, dst);
		// all-ones header and addresses, largest offset
		seg = header_segment(60, 15);
		foreach (seg[i])
			seg[i] = 8'hFF;
		seg = sealed(seg, '1, '1);
		queue_segment(seg, '1, '1);
		// all-zero header apart from the offset
		seg = header_segment(20, 5);
		foreach (seg[i])
			seg[i] = 8'h00;
		seg[12] = 8'h50;
		seg = sealed(seg, '0, '0);
		queue_segment(seg, '0, '0);
		// odd length pads the trailing byte
		src = $urandom();
		dst = $urandom();
		seg = sealed(header_segment(21, 5), src, dst);
		queue_segment(seg, src, dst);
		seg = sealed(header_segment(20, 5), src, dst);
		seg[17] ^= 8'h01;
		queue_segment(seg, src, dst);
		seg = sealed(header_segment(43, 10), src, dst);
		queue_segment(seg, src, dst);
		seg[40] ^= 8'h80;
		queue_segment(seg, src, dst);
		seg = header_segment(20, 5);
		seg[12] = 8'h5F;
		seg = sealed(seg, src, dst);
		queue_segment(seg, src, dst);

		while (wire_bytes.size() < 1700) begin
			src  = $urandom();
			dst  = $urandom();
			pick = $urandom_range(0, 99);
			doff = $urandom_range(5, 15);
			if (pick < 78) begin
				seg = header_segment(4 * doff + (($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 300) : $urandom_range(0, 40)), doff);
				seg = sealed(seg, src, dst);
				// corrupt one bit in a share of the well-formed segments
				if (pick >= 65) begin
					idx = $urandom_range(0, seg.size() - 1);
					seg[idx] ^= 8'(1 << $urandom_range(0, 7));
				end
			end else if (pick < 86) begin
				seg = header_segment($urandom_range(1, 19), $urandom_range(0, 15));
			end else if (pick < 93) begin
				doff = $urandom_range(6, 15);
				seg = header_segment($urandom_range(20, 4 * doff - 1), doff);
			end else begin
				seg = header_segment($urandom_range(1, 64), $urandom_range(0, 15));
			end
			queue_segment(seg, src, dst);
		end

		cycle_limit = 16 * longint'(wire_bytes.size()) + 20 * longint'(total_segments) + 5000;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (wire_bytes.size() != 0 || s_tvalid || awaited_verdicts.size() != 0);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Input driver
	wire_beat_t next_beat;
	int         gap_left  = 0;
	logic       src_calm  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0 || wire_bytes.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				next_beat = wire_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {next_beat.dst, next_beat.src, next_beat.data};
				s_tlast  <= next_beat.last;
				if ($urandom_range(0, 39) == 0)
					src_calm <= !src_calm;
				gap_left <= src_calm ? 0 : $urandom_range(0, 3);
			end
		end
	end

	// Result sink with random stalls
	int   stall_left = 0;
	int   stall_draw;
	logic sink_calm  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			if ($urandom_range(0, 9) == 0)
				sink_calm <= !sink_calm;
			stall_draw = sink_calm ? 0 : $urandom_range(0, 3);
			stall_left <= stall_draw;
			m_tready   <= (stall_draw == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predict on each input transaction, check each result transaction
	segment_verdict_t want;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			absorb_segment_byte(s_tdata[7:0], s_tdata[39:8], s_tdata[71:40], s_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_verdicts.size() == 0) begin
				report_mismatch("unexpected result", 32'(m_tdata[2:0]), 32'h0);
			end else begin
				want = awaited_verdicts.pop_front();
				compare_field("status", 32'(m_tdata[2:0]), 32'(want.status));
				compare_field("source_port", 32'(m_tdata[18:3]), 32'(want.hdr.source_port));
				compare_field("dest_port", 32'(m_tdata[34:19]), 32'(want.hdr.dest_port));
				compare_field("seq_number", m_tdata[66:35], want.hdr.seq_number);
				compare_field("ack_number", m_tdata[98:67], want.hdr.ack_number);
				compare_field("offset_byte", 32'(m_tdata[106:99]), 32'(want.hdr.offset_byte));
				compare_field("flag_bits", 32'(m_tdata[114:107]), 32'(want.hdr.flag_bits));
				compare_field("window", 32'(m_tdata[130:115]), 32'(want.hdr.window));
				compare_field("checksum_word", 32'(m_tdata[146:131]),
					32'(want.hdr.checksum_word));
				compare_field("urgent_pointer", 32'(m_tdata[162:147]),
					32'(want.hdr.urgent_pointer));
				compare_field("padding", 32'(m_tdata[167:163]), 32'h0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
